// File: design/mip_layout_transition_tracker_macros.svh
// Assertion macros shared by the tracker RTL.
`ifndef MIP_LAYOUT_TRANSITION_TRACKER_MACROS_SVH
`define MIP_LAYOUT_TRANSITION_TRACKER_MACROS_SVH

// The condition implies the property in the same cycle.
`define MLTT_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("mltt assertion failed");

// The condition implies the property in the next cycle.
`define MLTT_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("mltt assertion failed");

`endif

// File: design/mltt_pkg.sv
package mltt_pkg;

  localparam int RESOURCES_DEF = 64;
  localparam int MIP_MAX_DEF = 16;
  localparam int FRAME_SLOTS_DEF = 3;
  localparam int RELEASES_PER_SLOT_DEF = 16;

  localparam logic [1:0] KIND_REG   = 2'd0;
  localparam logic [1:0] KIND_BAR   = 2'd1;
  localparam logic [1:0] KIND_UNREG = 2'd2;
  localparam logic [1:0] KIND_FRAME = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_RANGE   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_DUP     = 3'd4;
  localparam logic [2:0] ST_IGNORED = 3'd5;
  localparam logic [2:0] ST_QFULL   = 3'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] uid;
    logic [4:0]  mip_cnt;
    logic [5:0]  layout;
    logic [3:0]  base_mip;
    logic [4:0]  level_count;
    logic [31:0] src_mask;
    logic [31:0] dst_mask;
  } in_item_t;

  typedef struct packed {
    logic        barrier_valid;
    logic [31:0] out_uid;
    logic [5:0]  old_layout;
    logic [5:0]  new_layout;
    logic [3:0]  first_mip;
    logic [4:0]  mip_span;
    logic [31:0] out_src_mask;
    logic [31:0] out_dst_mask;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_REG_FILL,
    S_WALK_RD,
    S_WALK_CHK,
    S_WALK_END,
    S_WALK_LAST,
    S_REL_RD,
    S_RESP
  } state_t;

endpackage

// File: design/mltt_ram.sv
module mltt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/mip_layout_transition_tracker.sv
// Channel   Handshake                   Payload
// input     in_valid / in_ready         in_data  (mltt_pkg::in_item_t)
// result    out_valid / out_ready       out_data (mltt_pkg::out_item_t)
//
// One item is worked on at a time: it is accepted, worked on as below, then
// its result is given. A uid lookup walks the entry table one entry at a time,
// reading each entry and then comparing it. A barrier then reads and checks
// each mip in its range and closes the walk; a register writes one mip per
// cycle; and a begin-frame item reads each queued release, then looks it up.
// Reset is synchronous and clears the used bits, release counts and slot.
// A stalled result channel holds the block in place without losing work.

`include "mip_layout_transition_tracker_macros.svh"

module mip_layout_transition_tracker #(
  parameter int RESOURCES = mltt_pkg::RESOURCES_DEF,
  parameter int MIP_MAX = mltt_pkg::MIP_MAX_DEF,
  parameter int FRAME_SLOTS = mltt_pkg::FRAME_SLOTS_DEF,
  parameter int RELEASES_PER_SLOT = mltt_pkg::RELEASES_PER_SLOT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mltt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mltt_pkg::out_item_t out_data
);

  // Address and counter widths.
  localparam int IW  = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int LD  = RESOURCES * MIP_MAX;
  localparam int LAW = (LD > 1) ? $clog2(LD) : 1;
  localparam int RD  = FRAME_SLOTS * RELEASES_PER_SLOT;
  localparam int RAW = (RD > 1) ? $clog2(RD) : 1;
  localparam int SW  = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int CW  = $clog2(RELEASES_PER_SLOT + 1);

  mltt_pkg::state_t state_r, state_nxt;

  // The item under work and its precomputed range end.
  mltt_pkg::in_item_t item_r, item_nxt;
  logic [5:0]         end_r, end_nxt;
  logic [2:0]         st_r, st_nxt;

  // Entry table bookkeeping; the uid and mip count live in u_uid_ram.
  logic [RESOURCES-1:0] used_r, used_nxt;
  logic [IW-1:0]        scan_idx_r, scan_idx_nxt;
  logic                 free_vld_r, free_vld_nxt;
  logic [IW-1:0]        free_idx_r, free_idx_nxt;
  logic [IW-1:0]        e_r, e_nxt;

  // Mip walk and the record held back until its successor is known.
  logic [4:0] m_r, m_nxt;
  logic [5:0] run_old_r, run_old_nxt;
  logic [3:0] run_start_r, run_start_nxt;
  logic       pend_vld_r, pend_vld_nxt;
  logic [5:0] pend_old_r, pend_old_nxt;
  logic [3:0] pend_first_r, pend_first_nxt;
  logic [4:0] pend_span_r, pend_span_nxt;

  // Deferred release ring.
  logic [CW-1:0] rel_cnt_r [FRAME_SLOTS];
  logic [CW-1:0] rel_cnt_nxt [FRAME_SLOTS];
  logic [SW-1:0] slot_r, slot_nxt;
  logic [CW-1:0] rel_i_r, rel_i_nxt;

  // Result register.
  logic                out_vld_r;
  mltt_pkg::out_item_t out_r, out_nxt;
  logic                out_ld;

  // Memory ports.
  logic           uid_we, uid_re;
  logic [IW-1:0]  uid_waddr;
  logic [36:0]    uid_wdata, uid_rdata;
  logic           lay_we, lay_re;
  logic [LAW-1:0] lay_addr;
  logic [5:0]     lay_rdata;
  logic           rel_we, rel_re;
  logic [RAW-1:0] rel_waddr, rel_raddr;
  logic [31:0]    rel_rdata;

  // Shared decode.
  logic          in_acc, out_free;
  logic [31:0]   key;
  logic          scan_hit, scan_last, free_here, have_free;
  logic          reg_bad, bar_bad;
  logic          run_new, brk, close_emit, chk_stall, walk_last, final_emit;
  logic          fill_done, rel_done;
  logic [SW-1:0] slot_adv;
  mltt_pkg::out_item_t rec_pend, rec_stat;

  assign in_ready  = (state_r == mltt_pkg::S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_vld_r || out_ready;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // A begin-frame lookup searches for the queued uid, all others for the input uid.
  assign key       = (item_r.kind == mltt_pkg::KIND_FRAME) ? rel_rdata : item_r.uid;
  assign scan_hit  = used_r[scan_idx_r] && (uid_rdata[31:0] == key);
  assign scan_last = (scan_idx_r == IW'(RESOURCES - 1));
  assign free_here = !used_r[scan_idx_r];
  assign have_free = free_vld_r || free_here;
  assign reg_bad   = (item_r.mip_cnt == 5'd0) || (item_r.mip_cnt > 5'(MIP_MAX));
  assign bar_bad   = (end_r > {1'b0, uid_rdata[36:32]}) || (end_r > 6'(MIP_MAX));

  // A run breaks when the stored layout changes; it is reported only when
  // its layout differs from the new one.
  assign run_new    = (m_r == {1'b0, item_r.base_mip});
  assign brk        = !run_new && (lay_rdata != run_old_r);
  assign close_emit = brk && (run_old_r != item_r.layout);
  assign chk_stall  = close_emit && pend_vld_r && !out_free;
  assign walk_last  = ({1'b0, m_r} + 6'd1 == end_r);
  assign final_emit = (run_old_r != item_r.layout);

  assign fill_done = (m_r + 5'd1 == item_r.mip_cnt);
  assign rel_done  = (rel_i_r + CW'(1) == rel_cnt_r[slot_r]);
  assign slot_adv  = (slot_r == SW'(FRAME_SLOTS - 1)) ? '0 : slot_r + SW'(1);

  assign lay_addr  = LAW'(e_r) * LAW'(MIP_MAX) + LAW'(m_r);
  assign rel_raddr = RAW'(slot_r) * RAW'(RELEASES_PER_SLOT) + RAW'(rel_i_r);

  always_comb begin
    rec_pend               = '0;
    rec_pend.barrier_valid = 1'b1;
    rec_pend.out_uid       = item_r.uid;
    rec_pend.old_layout    = pend_old_r;
    rec_pend.new_layout    = item_r.layout;
    rec_pend.first_mip     = pend_first_r;
    rec_pend.mip_span      = pend_span_r;
    rec_pend.out_src_mask  = item_r.src_mask;
    rec_pend.out_dst_mask  = item_r.dst_mask;
    rec_pend.status        = mltt_pkg::ST_OK;
    rec_stat               = '0;
    rec_stat.out_uid       = item_r.uid;
    rec_stat.status        = st_r;
    rec_stat.last          = 1'b1;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mltt_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_data.kind)
            mltt_pkg::KIND_REG: state_nxt = mltt_pkg::S_SCAN_RD;
            mltt_pkg::KIND_BAR: begin
              state_nxt = (in_data.level_count == 5'd0) ? mltt_pkg::S_RESP
                                                        : mltt_pkg::S_SCAN_RD;
            end
            mltt_pkg::KIND_UNREG: state_nxt = mltt_pkg::S_RESP;
            default: begin
              state_nxt = (rel_cnt_r[slot_adv] == '0) ? mltt_pkg::S_RESP
                                                      : mltt_pkg::S_REL_RD;
            end
          endcase
        end
      end
      mltt_pkg::S_SCAN_RD: state_nxt = mltt_pkg::S_SCAN_CMP;
      mltt_pkg::S_SCAN_CMP: begin
        if (scan_hit || scan_last) begin
          case (item_r.kind)
            mltt_pkg::KIND_REG: begin
              state_nxt = (scan_hit || reg_bad || !have_free) ? mltt_pkg::S_RESP
                                                              : mltt_pkg::S_REG_FILL;
            end
            mltt_pkg::KIND_BAR: begin
              state_nxt = (scan_hit && !bar_bad) ? mltt_pkg::S_WALK_RD
                                                 : mltt_pkg::S_RESP;
            end
            mltt_pkg::KIND_FRAME: begin
              state_nxt = rel_done ? mltt_pkg::S_RESP : mltt_pkg::S_REL_RD;
            end
            default: state_nxt = mltt_pkg::S_RESP;
          endcase
        end else begin
          state_nxt = mltt_pkg::S_SCAN_RD;
        end
      end
      mltt_pkg::S_REG_FILL: begin
        if (fill_done) begin
          state_nxt = mltt_pkg::S_RESP;
        end
      end
      mltt_pkg::S_WALK_RD: state_nxt = mltt_pkg::S_WALK_CHK;
      mltt_pkg::S_WALK_CHK: begin
        if (!chk_stall) begin
          state_nxt = walk_last ? mltt_pkg::S_WALK_END : mltt_pkg::S_WALK_RD;
        end
      end
      mltt_pkg::S_WALK_END: begin
        if (!(final_emit && pend_vld_r && !out_free)) begin
          state_nxt = mltt_pkg::S_WALK_LAST;
        end
      end
      mltt_pkg::S_WALK_LAST: begin
        if (out_free) begin
          state_nxt = mltt_pkg::S_IDLE;
        end
      end
      mltt_pkg::S_REL_RD: state_nxt = mltt_pkg::S_SCAN_RD;
      mltt_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = mltt_pkg::S_IDLE;
        end
      end
      default: state_nxt = mltt_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory strobes and result loads.
  always_comb begin
    item_nxt       = item_r;
    end_nxt        = end_r;
    st_nxt         = st_r;
    used_nxt       = used_r;
    scan_idx_nxt   = scan_idx_r;
    free_vld_nxt   = free_vld_r;
    free_idx_nxt   = free_idx_r;
    e_nxt          = e_r;
    m_nxt          = m_r;
    run_old_nxt    = run_old_r;
    run_start_nxt  = run_start_r;
    pend_vld_nxt   = pend_vld_r;
    pend_old_nxt   = pend_old_r;
    pend_first_nxt = pend_first_r;
    pend_span_nxt  = pend_span_r;
    rel_cnt_nxt    = rel_cnt_r;
    slot_nxt       = slot_r;
    rel_i_nxt      = rel_i_r;
    out_ld         = 1'b0;
    out_nxt        = rec_stat;
    uid_we         = 1'b0;
    uid_re         = 1'b0;
    uid_waddr      = free_vld_r ? free_idx_r : scan_idx_r;
    uid_wdata      = {item_r.mip_cnt, item_r.uid};
    lay_we         = 1'b0;
    lay_re         = 1'b0;
    rel_we         = 1'b0;
    rel_re         = 1'b0;
    rel_waddr      = RAW'(slot_r) * RAW'(RELEASES_PER_SLOT) + RAW'(rel_cnt_r[slot_r]);
    case (state_r)
      mltt_pkg::S_IDLE: begin
        if (in_acc) begin
          item_nxt     = in_data;
          end_nxt      = {2'b00, in_data.base_mip} + {1'b0, in_data.level_count};
          scan_idx_nxt = '0;
          free_vld_nxt = 1'b0;
          rel_i_nxt    = '0;
          st_nxt       = mltt_pkg::ST_OK;
          case (in_data.kind)
            mltt_pkg::KIND_BAR: begin
              if (in_data.level_count == 5'd0) begin
                st_nxt = mltt_pkg::ST_IGNORED;
              end
            end
            mltt_pkg::KIND_UNREG: begin
              if (rel_cnt_r[slot_r] == CW'(RELEASES_PER_SLOT)) begin
                st_nxt = mltt_pkg::ST_QFULL;
              end else begin
                rel_we              = 1'b1;
                rel_cnt_nxt[slot_r] = rel_cnt_r[slot_r] + CW'(1);
              end
            end
            mltt_pkg::KIND_FRAME: slot_nxt = slot_adv;
            default: ;
          endcase
        end
      end
      mltt_pkg::S_SCAN_RD: uid_re = 1'b1;
      mltt_pkg::S_SCAN_CMP: begin
        if (!free_vld_r && free_here) begin
          free_vld_nxt = 1'b1;
          free_idx_nxt = scan_idx_r;
        end
        if (scan_hit || scan_last) begin
          scan_idx_nxt = '0;
          case (item_r.kind)
            mltt_pkg::KIND_REG: begin
              if (scan_hit) begin
                st_nxt = mltt_pkg::ST_DUP;
              end else if (reg_bad) begin
                st_nxt = mltt_pkg::ST_RANGE;
              end else if (!have_free) begin
                st_nxt = mltt_pkg::ST_FULL;
              end else begin
                uid_we = 1'b1;
                e_nxt  = uid_waddr;
                used_nxt[uid_waddr] = 1'b1;
                m_nxt  = 5'd0;
              end
            end
            mltt_pkg::KIND_BAR: begin
              e_nxt        = scan_idx_r;
              m_nxt        = {1'b0, item_r.base_mip};
              pend_vld_nxt = 1'b0;
              if (!scan_hit) begin
                st_nxt = mltt_pkg::ST_UNKNOWN;
              end else if (bar_bad) begin
                st_nxt = mltt_pkg::ST_RANGE;
              end
            end
            mltt_pkg::KIND_FRAME: begin
              if (scan_hit) begin
                used_nxt[scan_idx_r] = 1'b0;
              end
              rel_i_nxt = rel_i_r + CW'(1);
              if (rel_done) begin
                rel_cnt_nxt[slot_r] = '0;
              end
            end
            default: ;
          endcase
        end else begin
          scan_idx_nxt = scan_idx_r + IW'(1);
        end
      end
      mltt_pkg::S_REG_FILL: begin
        lay_we = 1'b1;
        m_nxt  = m_r + 5'd1;
      end
      mltt_pkg::S_WALK_RD: lay_re = 1'b1;
      mltt_pkg::S_WALK_CHK: begin
        if (!chk_stall) begin
          lay_we = 1'b1;
          m_nxt  = m_r + 5'd1;
          if (run_new || brk) begin
            run_old_nxt   = lay_rdata;
            run_start_nxt = m_r[3:0];
          end
          if (close_emit) begin
            pend_vld_nxt   = 1'b1;
            pend_old_nxt   = run_old_r;
            pend_first_nxt = run_start_r;
            pend_span_nxt  = m_r - {1'b0, run_start_r};
            if (pend_vld_r) begin
              out_ld  = 1'b1;
              out_nxt = rec_pend;
            end
          end
        end
      end
      mltt_pkg::S_WALK_END: begin
        if (final_emit && (!pend_vld_r || out_free)) begin
          pend_vld_nxt   = 1'b1;
          pend_old_nxt   = run_old_r;
          pend_first_nxt = run_start_r;
          pend_span_nxt  = end_r[4:0] - {1'b0, run_start_r};
          if (pend_vld_r) begin
            out_ld  = 1'b1;
            out_nxt = rec_pend;
          end
        end
      end
      mltt_pkg::S_WALK_LAST: begin
        if (out_free) begin
          out_ld = 1'b1;
          if (pend_vld_r) begin
            out_nxt      = rec_pend;
            out_nxt.last = 1'b1;
          end
          pend_vld_nxt = 1'b0;
        end
      end
      mltt_pkg::S_REL_RD: begin
        rel_re       = 1'b1;
        scan_idx_nxt = '0;
      end
      mltt_pkg::S_RESP: out_ld = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mltt_pkg::S_IDLE;
      used_r     <= '0;
      slot_r     <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      for (int s = 0; s < FRAME_SLOTS; s++) begin
        rel_cnt_r[s] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      slot_r     <= slot_nxt;
      pend_vld_r <= pend_vld_nxt;
      rel_cnt_r  <= rel_cnt_nxt;
      if (out_ld) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    end_r        <= end_nxt;
    st_r         <= st_nxt;
    scan_idx_r   <= scan_idx_nxt;
    free_vld_r   <= free_vld_nxt;
    free_idx_r   <= free_idx_nxt;
    e_r          <= e_nxt;
    m_r          <= m_nxt;
    run_old_r    <= run_old_nxt;
    run_start_r  <= run_start_nxt;
    pend_old_r   <= pend_old_nxt;
    pend_first_r <= pend_first_nxt;
    pend_span_r  <= pend_span_nxt;
    rel_i_r      <= rel_i_nxt;
    if (out_ld) begin
      out_r <= out_nxt;
    end
  end

  // Uid and mip count per entry.
  mltt_ram #(.WIDTH(37), .DEPTH(RESOURCES)) u_uid_ram (
    .clk   (clk),
    .we    (uid_we),
    .waddr (uid_waddr),
    .wdata (uid_wdata),
    .re    (uid_re),
    .raddr (scan_idx_r),
    .rdata (uid_rdata)
  );

  // Layout code per mip, one row of MIP_MAX words per entry.
  mltt_ram #(.WIDTH(6), .DEPTH(LD)) u_lay_ram (
    .clk   (clk),
    .we    (lay_we),
    .waddr (lay_addr),
    .wdata (item_r.layout),
    .re    (lay_re),
    .raddr (lay_addr),
    .rdata (lay_rdata)
  );

  // Queued uids, one row of RELEASES_PER_SLOT words per frame slot.
  mltt_ram #(.WIDTH(32), .DEPTH(RD)) u_rel_ram (
    .clk   (clk),
    .we    (rel_we),
    .waddr (rel_waddr),
    .wdata (in_data.uid),
    .re    (rel_re),
    .raddr (rel_raddr),
    .rdata (rel_rdata)
  );

  `MLTT_ASSERT_IMP(a_rec_changes, out_vld_r && out_r.barrier_valid, out_r.old_layout != out_r.new_layout)
  `MLTT_ASSERT_IMP(a_status_last, out_vld_r && !out_r.barrier_valid, out_r.last)
  `MLTT_ASSERT_IMP(a_slot_range, 1'b1, slot_r <= SW'(FRAME_SLOTS - 1))
  `MLTT_ASSERT_IMP(a_rel_bound, 1'b1, rel_cnt_r[slot_r] <= CW'(RELEASES_PER_SLOT))
  `MLTT_ASSERT_NXT(a_one_item, in_acc, !in_ready)

endmodule
